// ===== src/u32x4_pkg.sv =====
// Shared types and constants for the four-lane unsigned ALU.
// No dependencies.
package u32x4_pkg;

    localparam int LANES = 4;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [3:0] FUNC_BUILD = 4'd0;
    localparam logic [3:0] FUNC_SPLAT = 4'd1;
    localparam logic [3:0] FUNC_SHR   = 4'd2;
    localparam logic [3:0] FUNC_LT    = 4'd3;
    localparam logic [3:0] FUNC_LE    = 4'd4;
    localparam logic [3:0] FUNC_GT    = 4'd5;
    localparam logic [3:0] FUNC_GE    = 4'd6;
    localparam logic [3:0] FUNC_MIN   = 4'd7;
    localparam logic [3:0] FUNC_MAX   = 4'd8;
    localparam logic [3:0] FUNC_FLT   = 4'd9;

    typedef logic [31:0] word_t;

    // Per-lane outcome passed to the merge stage.
    typedef struct packed {
        word_t value;
        logic  bad;
    } lane_res_t;

endpackage

// ===== src/uint32x4_lane_alu_unit.sv =====
// Top level of the four-lane unsigned ALU: lanes, error merge, output register.
// Depends on u32x4_pkg and u32x4_lane.
//
// One beat in, one beat out, with the result registered; a new beat is taken every
// cycle while the single output register is empty or being drained. Lane
// logic is combinational into that register, so throughput is one vector per
// cycle while the output is not stalled.
module uint32x4_lane_alu_unit import u32x4_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_func,
    input  logic [31:0] s_a_lane0,
    input  logic [31:0] s_a_lane1,
    input  logic [31:0] s_a_lane2,
    input  logic [31:0] s_a_lane3,
    input  logic [31:0] s_b_lane0,
    input  logic [31:0] s_b_lane1,
    input  logic [31:0] s_b_lane2,
    input  logic [31:0] s_b_lane3,
    input  logic [4:0]  s_shift_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_r_lane0,
    output logic [31:0] m_r_lane1,
    output logic [31:0] m_r_lane2,
    output logic [31:0] m_r_lane3,
    output logic        m_range_error
);

    word_t     a_vec [LANES];
    word_t     b_vec [LANES];
    lane_res_t lres  [LANES];
    word_t     r_reg [LANES];
    logic      err_any;
    logic      err_reg;
    logic      valid_reg;

    assign a_vec[0] = s_a_lane0;
    assign a_vec[1] = s_a_lane1;
    assign a_vec[2] = s_a_lane2;
    assign a_vec[3] = s_a_lane3;
    assign b_vec[0] = s_b_lane0;
    assign b_vec[1] = s_b_lane1;
    assign b_vec[2] = s_b_lane2;
    assign b_vec[3] = s_b_lane3;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        u32x4_lane u_lane (
            .func        (s_func),
            .a           (a_vec[i]),
            .a0          (a_vec[0]),
            .b           (b_vec[i]),
            .shift_count (s_shift_count),
            .res         (lres[i])
        );
    end

    // Merge lane errors
    assign err_any = lres[0].bad | lres[1].bad | lres[2].bad | lres[3].bad;
    assign s_ready = !valid_reg || m_ready;

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Load result beat, zeroing all lanes on an error
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            err_reg <= err_any;
            for (int i = 0; i < LANES; i++) begin
                r_reg[i] <= err_any ? '0 : lres[i].value;
            end
        end
    end

    assign m_valid       = valid_reg;
    assign m_r_lane0     = r_reg[0];
    assign m_r_lane1     = r_reg[1];
    assign m_r_lane2     = r_reg[2];
    assign m_r_lane3     = r_reg[3];
    assign m_range_error = err_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> (m_r_lane0 | m_r_lane1 | m_r_lane2 | m_r_lane3) == '0)
        else $error("error beat has nonzero lanes");
    a_err_func: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func != FUNC_FLT |=> !m_range_error)
        else $error("range error outside conversion");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r_lane0))
        else $error("stalled result changed");

endmodule

// ===== src/u32x4_lane.sv =====
// One ALU lane: build, splat, compares, shift, min/max and float32 to uint32 conversion.
// Depends on u32x4_pkg.
module u32x4_lane import u32x4_pkg::*; (
    input  logic [3:0] func,
    input  word_t      a,
    input  word_t      a0,
    input  word_t      b,
    input  logic [4:0] shift_count,
    output lane_res_t  res
);

    logic       a_lt_b;
    logic [7:0] expo;
    logic [4:0] e;
    logic [54:0] sig;
    word_t      cvt;
    logic       cvt_bad;

    assign a_lt_b = a < b;

    // Convert float bits: shift the 24-bit significand by exponent
    always_comb begin
        expo    = a[30:23];
        e       = expo[4:0] + 5'd1;
        sig     = {31'd0, 1'b1, a[22:0]} << e;
        cvt     = 32'd0;
        cvt_bad = 1'b0;
        if (expo == 8'hFF) begin
            cvt_bad = 1'b1;
        end else if (expo < 8'd127) begin
            cvt = 32'd0;
        end else if (a[31]) begin
            cvt_bad = 1'b1;
        end else if (expo >= 8'd159) begin
            cvt_bad = 1'b1;
        end else begin
            cvt = sig[54:23];
        end
    end

    // Select the operation result
    always_comb begin
        res.bad = 1'b0;
        case (func)
            FUNC_BUILD: res.value = a;
            FUNC_SPLAT: res.value = a0;
            FUNC_SHR:   res.value = a >> shift_count;
            FUNC_LT:    res.value = a_lt_b ? ALL_ONES : '0;
            FUNC_LE:    res.value = (a <= b) ? ALL_ONES : '0;
            FUNC_GT:    res.value = (a > b) ? ALL_ONES : '0;
            FUNC_GE:    res.value = !a_lt_b ? ALL_ONES : '0;
            FUNC_MIN:   res.value = a_lt_b ? a : b;
            FUNC_MAX:   res.value = (b < a) ? a : b;
            FUNC_FLT: begin
                res.value = cvt;
                res.bad   = cvt_bad;
            end
            default:    res.value = '0;
        endcase
    end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the four-lane unsigned ALU (uint32x4_lane_alu_unit).
// Depends on u32x4_pkg; predicts each result vector and compares it beat by beat.
`timescale 1ns / 1ps

module tb;
    import u32x4_pkg::*;

    typedef struct {
        word_t r [LANES];
        logic  err;
    } alu_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_func;
    logic [31:0] s_a_lane0, s_a_lane1, s_a_lane2, s_a_lane3;
    logic [31:0] s_b_lane0, s_b_lane1, s_b_lane2, s_b_lane3;
    logic [4:0]  s_shift_count;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_r_lane0, m_r_lane1, m_r_lane2, m_r_lane3;
    logic        m_range_error;

    alu_result_t expected_q[$];
    int          mismatch_count;
    bit          hold_off;
    bit          stall_enable;

    uint32x4_lane_alu_unit dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("** uint32x4_lane_alu_unit: FAILED **");
        $finish;
    end

    // Truncate one float32 pattern toward zero; returns 0 when out of range.
    function automatic bit float_to_u32(input word_t f, output word_t val);
        logic [7:0]  expo;
        int          e;
        logic [63:0] sig;
        expo = f[30:23];
        val = '0;
        if (expo == 8'hFF) return 1'b0;
        if (expo < 8'd127) return 1'b1;
        if (f[31]) return 1'b0;
        e = int'(expo) - 127;
        if (e >= 32) return 1'b0;
        sig = {40'd0, 1'b1, f[22:0]};
        if (e >= 23) sig = sig << (e - 23);
        else sig = sig >> (23 - e);
        val = sig[31:0];
        return 1'b1;
    endfunction

    function automatic alu_result_t compute_lanes(input logic [3:0] fn, input word_t a [LANES],
                                                  input word_t b [LANES], input logic [4:0] sh);
        alu_result_t res;
        word_t       v;
        res.err = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            res.r[i] = '0;
            case (fn)
                FUNC_BUILD: res.r[i] = a[i];
                FUNC_SPLAT: res.r[i] = a[0];
                FUNC_SHR:   res.r[i] = a[i] >> sh;
                FUNC_LT:    res.r[i] = (a[i] <  b[i]) ? ALL_ONES : '0;
                FUNC_LE:    res.r[i] = (a[i] <= b[i]) ? ALL_ONES : '0;
                FUNC_GT:    res.r[i] = (a[i] >  b[i]) ? ALL_ONES : '0;
                FUNC_GE:    res.r[i] = (a[i] >= b[i]) ? ALL_ONES : '0;
                FUNC_MIN:   res.r[i] = (a[i] < b[i]) ? a[i] : b[i];
                FUNC_MAX:   res.r[i] = (b[i] < a[i]) ? a[i] : b[i];
                FUNC_FLT: begin
                    if (!float_to_u32(a[i], v)) res.err = 1'b1;
                    res.r[i] = v;
                end
                default:    res.r[i] = '0;
            endcase
        end
        if (res.err) for (int i = 0; i < LANES; i++) res.r[i] = '0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one beat, then optionally idle a random gap.
    task automatic send_vector(input logic [3:0] fn, input word_t a [LANES],
                               input word_t b [LANES], input logic [4:0] sh, input bit gaps);
        int gap;
        s_valid <= 1'b1;
        s_func <= fn;
        s_a_lane0 <= a[0]; s_a_lane1 <= a[1]; s_a_lane2 <= a[2]; s_a_lane3 <= a[3];
        s_b_lane0 <= b[0]; s_b_lane1 <= b[1]; s_b_lane2 <= b[2]; s_b_lane3 <= b[3];
        s_shift_count <= sh;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(compute_lanes(fn, a, b, sh));
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic release_bus();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES;
            2: return SIGN_BIT;
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t rand_float();
        logic [7:0] expo;
        case ($urandom_range(0, 4))
            0: expo = $urandom_range(0, 126);
            1: expo = 8'hFF;
            2: expo = $urandom_range(158, 254);
            default: expo = $urandom_range(127, 158);
        endcase
        return {($urandom_range(0, 3) == 0), expo, 23'($urandom)};
    endfunction

    // Result side: randomly stall, check each accepted beat.
    initial begin
        alu_result_t want;
        logic [31:0] got [LANES];
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off) m_ready <= 1'b0;
            else if (stall_enable) m_ready <= (pick_gap() == 0);
            else m_ready <= 1'b1;
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_r_lane0, m_r_lane1, m_r_lane2, m_r_lane3};
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", got[0], '0);
                end else begin
                    want = expected_q.pop_front();
                    for (int i = 0; i < LANES; i++)
                        if (got[i] !== want.r[i]) report_mismatch($sformatf("lane%0d", i),
                                                                  got[i], want.r[i]);
                    if (m_range_error !== want.err)
                        report_mismatch("range_error", 32'(m_range_error), 32'(want.err));
                end
            end
        end
    end

    task automatic test_directed();
        word_t a [LANES];
        word_t b [LANES];
        a = '{32'd0, ALL_ONES, SIGN_BIT, 32'h1234_5678};
        b = '{32'd0, 32'd0, ALL_ONES, 32'h1234_5678};
        for (int f = 0; f < 16; f++) send_vector(4'(f), a, b, 5'd31, 1'b0);
        send_vector(FUNC_SHR, a, b, 5'd0, 1'b0);
        // In-range floats: 1.0, just under 2^32, 0.5, -0.0
        a = '{32'h3F80_0000, 32'h4F7F_FFFF, 32'h3F00_0000, SIGN_BIT};
        send_vector(FUNC_FLT, a, b, 5'd0, 1'b0);
        // Just above -1.0 converts to zero; -1.0 itself raises the error
        a = '{32'hBF7F_FFFF, 32'h0000_0001, 32'h4B00_0001, 32'h3F80_0000};
        send_vector(FUNC_FLT, a, b, 5'd0, 1'b0);
        a = '{32'hBF80_0000, 32'h0, 32'h0, 32'h0};
        send_vector(FUNC_FLT, a, b, 5'd0, 1'b0);
        a = '{32'h0, 32'h4F80_0000, 32'h0, 32'h0};
        send_vector(FUNC_FLT, a, b, 5'd0, 1'b0);
        a = '{32'h0, 32'h0, 32'h7FC0_0000, 32'h0};
        send_vector(FUNC_FLT, a, b, 5'd0, 1'b0);
        a = '{32'h0, 32'h0, 32'h0, 32'h7F80_0000};
        send_vector(FUNC_FLT, a, b, 5'd0, 1'b0);
        release_bus();
        wait_drained();
    endtask

    task automatic test_random(input int count);
        word_t      a [LANES];
        word_t      b [LANES];
        logic [3:0] fn;
        for (int n = 0; n < count; n++) begin
            fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            for (int i = 0; i < LANES; i++) begin
                a[i] = (fn == FUNC_FLT) ? rand_float() : rand_word();
                b[i] = ($urandom_range(0, 3) == 0) ? a[i] : rand_word();
            end
            send_vector(fn, a, b, 5'($urandom), 1'b1);
        end
        release_bus();
    endtask

    // Stall the output for a long stretch while input keeps coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (40) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(30);
        join
        wait_drained();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_func <= '0;
        {s_a_lane0, s_a_lane1, s_a_lane2, s_a_lane3} <= '0;
        {s_b_lane0, s_b_lane1, s_b_lane2, s_b_lane3} <= '0;
        s_shift_count <= '0;
        mismatch_count = 0;
        hold_off = 1'b0;
        stall_enable = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(200);
        wait_drained();
        stall_enable = 1'b1;
        test_random(1300);
        wait_drained();
        test_backpressure();
        stall_enable = 1'b0;
        test_random(80);
        wait_drained();

        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("** uint32x4_lane_alu_unit: PASSED **");
        else
            $display("** uint32x4_lane_alu_unit: FAILED **");
        $finish;
    end
endmodule
